@@ src/eight_bit_alu_with_flags_macros.svh @@
// Assertion macros used by the ALU top level.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define ALU8F_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, held off during reset.
`define ALU8F_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ALU8F_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ALU8F_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/alu8f_pkg.sv @@
// Types and constants of the eight-bit ALU.
package alu8f_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned BUS_W  = 24;

    localparam logic [DATA_W-1:0] SIGN_BIT = 8'h80;

    typedef enum logic [3:0] {
        OP_ADC  = 4'd0,
        OP_SBC  = 4'd1,
        OP_RLC  = 4'd2,
        OP_RRC  = 4'd3,
        OP_RL   = 4'd4,
        OP_RR   = 4'd5,
        OP_AND  = 4'd6,
        OP_XOR  = 4'd7,
        OP_OR   = 4'd8,
        OP_CPL  = 4'd9,
        OP_SWAP = 4'd10,
        OP_SET  = 4'd11,
        OP_GET  = 4'd12,
        OP_SLA  = 4'd13,
        OP_SRA  = 4'd14,
        OP_SRL  = 4'd15
    } t_opcode;

    typedef struct packed {
        t_opcode           opcode;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic              carry_in;
        logic [IDX_W-1:0]  bit_index;
    } t_alu_req;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              zero_flag;
        logic              subtract_flag;
        logic              half_carry_flag;
        logic              carry_flag;
        logic              low_bit;
        logic              high_bit;
        logic [DATA_W-1:0] operand_bits;
    } t_alu_rsp;

endpackage

@@ src/alu8f_in_stage.sv @@
// Input register: unpacks and holds one item for the execute logic.
module alu8f_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [alu8f_pkg::BUS_W-1:0] i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output alu8f_pkg::t_alu_req         o_req
);
    import alu8f_pkg::*;

    logic     r_valid;
    t_alu_req r_req;
    t_alu_req n_req;

    // Free when empty or when the held item moves on this cycle.
    assign o_ready = !r_valid || i_ready;

    // tdata: opcode, operand_a, operand_b, carry_in, bit_index from bit 0 up.
    always_comb begin
        n_req.opcode    = t_opcode'(i_data[3:0]);
        n_req.operand_a = i_data[11:4];
        n_req.operand_b = i_data[19:12];
        n_req.carry_in  = i_data[20];
        n_req.bit_index = i_data[23:21];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

@@ src/alu8f_exec.sv @@
// Execute logic: one operation and its flags from a held item.
module alu8f_exec (
    input  alu8f_pkg::t_alu_req i_req,
    output alu8f_pkg::t_alu_rsp o_rsp
);
    import alu8f_pkg::*;

    logic [DATA_W:0]   sum;
    logic [DATA_W:0]   diff;
    logic [4:0]        sum_lo;
    logic [4:0]        diff_lo;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] r;
    logic              hc;
    logic              cy;
    logic              from_result;

    assign a    = i_req.operand_a;
    assign b    = i_req.operand_b;
    assign mask = 8'h01 << i_req.bit_index;

    // Carry-in is the third addend in the sums and is subtracted in the differences, for nibble and byte alike.
    assign sum     = {1'b0, a} + {1'b0, b} + {8'd0, i_req.carry_in};
    assign diff    = {1'b0, a} - {1'b0, b} - {8'd0, i_req.carry_in};
    assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, i_req.carry_in};
    assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, i_req.carry_in};

    always_comb begin
        r           = '0;
        hc          = 1'b0;
        cy          = 1'b0;
        from_result = 1'b0;
        case (i_req.opcode)
            OP_ADC: begin
                r = sum[DATA_W-1:0]; hc = sum_lo[4]; cy = sum[DATA_W]; from_result = 1'b1;
            end
            OP_SBC: begin
                r = diff[DATA_W-1:0]; hc = diff_lo[4]; cy = diff[DATA_W];
                from_result = 1'b1;
            end
            OP_RLC:  r = {a[6:0], a[7]};
            OP_RRC:  r = {a[0], a[7:1]};
            OP_RL:   r = {a[6:0], i_req.carry_in};
            OP_RR:   r = {i_req.carry_in, a[7:1]};
            OP_AND: begin r = a & b; from_result = 1'b1; end
            OP_XOR: begin r = a ^ b; from_result = 1'b1; end
            OP_OR:  begin r = a | b; from_result = 1'b1; end
            OP_CPL: begin r = ~a;    from_result = 1'b1; end
            OP_SWAP: r = {a[3:0], a[7:4]};
            OP_SET:  r = (a & ~mask) | (b[0] ? mask : '0);
            OP_GET:  r = {7'd0, a[i_req.bit_index]};
            OP_SLA:  r = {a[6:0], 1'b0};
            OP_SRA:  r = (a >> 1) | (a & SIGN_BIT);
            OP_SRL:  r = {1'b0, a[7:1]};
            default: r = '0;
        endcase
    end

    always_comb begin
        o_rsp.result          = r;
        o_rsp.zero_flag       = (r == '0);
        o_rsp.subtract_flag   = (i_req.opcode == OP_SBC);
        o_rsp.half_carry_flag = hc;
        o_rsp.carry_flag      = cy;
        o_rsp.low_bit         = from_result ? r[0] : a[0];
        o_rsp.high_bit        = from_result ? r[DATA_W-1] : a[DATA_W-1];
        o_rsp.operand_bits    = (i_req.opcode == OP_GET) ? a : '0;
    end

endmodule

@@ src/alu8f_out_stage.sv @@
// Result register: holds one finished item and packs it for the master side.
module alu8f_out_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  alu8f_pkg::t_alu_rsp         i_rsp,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [alu8f_pkg::BUS_W-1:0] o_data
);
    import alu8f_pkg::*;

    logic     r_valid;
    t_alu_rsp r_rsp;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {2'b00, r_rsp.operand_bits, r_rsp.high_bit, r_rsp.low_bit,
                      r_rsp.carry_flag, r_rsp.half_carry_flag, r_rsp.subtract_flag,
                      r_rsp.zero_flag, r_rsp.result};

endmodule

@@ src/eight_bit_alu_with_flags.sv @@
// Top level of the eight-bit ALU with flags.
//
// Usage: one operation per item on the slave stream (s_axis_*), one result item
// per operation on the master stream (m_axis_*), in order.
// s_axis_tdata from bit 0: opcode[3:0], operand_a[11:4], operand_b[19:12],
//   carry_in[20], bit_index[23:21].
// m_axis_tdata from bit 0: result[7:0], zero[8], subtract[9], half carry[10],
//   carry[11], low bit[12], high bit[13], operand_bits[21:14], zero fill [23:22].
// An accepted item passes through the input register, then through the execute
// logic into the result register, which drives the master side.
// Throughput: one item per cycle while the receiver keeps m_axis_tready high;
// both register stages advance together whenever the downstream one is free or being emptied.
// Reset (i_rst_n low, synchronous) empties both stages, dropping any items they hold;
// no item is invented and nothing else is held, since the ALU keeps no state.
// When the receiver stalls the result register holds its item, the input
// register fills behind it, and s_axis_tready drops only once both are full.
// Ready propagates back combinationally through the two stages.
`include "eight_bit_alu_with_flags_macros.svh"

module eight_bit_alu_with_flags (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // opcode, operand_a, operand_b, carry_in, bit_index (from bit 0 up)
    input  logic [alu8f_pkg::BUS_W-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // result, zero, subtract, half carry, carry, low bit, high bit, operand_bits
    output logic [alu8f_pkg::BUS_W-1:0] m_axis_tdata
);
    import alu8f_pkg::*;

    logic     s1_valid;
    logic     s2_ready;
    t_alu_req s1_req;
    t_alu_rsp s1_rsp;

    // Stage 1: input register.
    alu8f_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_req   (s1_req)
    );

    // Operation and flags, all in one pass.
    alu8f_exec u_exec (
        .i_req (s1_req),
        .o_rsp (s1_rsp)
    );

    // Stage 2: result register feeding the master side.
    alu8f_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s2_ready),
        .i_rsp   (s1_rsp),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

    // Zero flag agrees with the result byte.
    `ALU8F_ASSERT_IMP(a_zero_flag, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[8] == (m_axis_tdata[7:0] == 8'd0))
    // Only a bit test reports operand bits, and its result is a single bit.
    `ALU8F_ASSERT_IMP(a_get_result, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tdata[21:14] != 8'd0),
        m_axis_tdata[7:1] == 7'd0 && !m_axis_tdata[9])
    // A held item that moves on lands in the result register.
    `ALU8F_ASSERT_NXT(a_advance, i_clk, i_rst_n, s1_valid && s2_ready, m_axis_tvalid)

endmodule
